// ----- hdl/swmd_pkg.sv -----
// Shared types, sizes and helpers for the stack with middle delete.
// Used by swmd_cell, swmd_row and stack_with_middle_delete_core; no dependencies.
package swmd_pkg;

	localparam int DEPTH = 128;
	localparam int WIDTH = 32;

	// Field widths of the words on the ports.
	localparam int VALUE_W = 32;
	localparam int COUNT_FIELD_W = 8;

	// Internal count and the two halves of the stack.
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ROW_LEN = DEPTH - DEPTH / 2;
	localparam int IDX_W = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_DELMID = 2'd2,
		OP_QUERY  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SH_HOLD        = 2'd0,
		SH_FROM_LOWER  = 2'd1,
		SH_FROM_HIGHER = 2'd2
	} shift_t;

	typedef struct packed {
		opcode_t              opcode;
		logic [VALUE_W-1:0]   push_value;
	} cmd_word_t;

	typedef struct packed {
		status_t                  status;
		logic [VALUE_W-1:0]       top_value;
		logic [VALUE_W-1:0]       middle_value;
		logic [COUNT_FIELD_W-1:0] entry_count;
		logic                     is_empty;
	} res_word_t;

	typedef struct packed {
		shift_t           shift;
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
	} row_ctl_t;

	typedef struct packed {
		shift_t shift;
		logic   load;
	} cell_ctl_t;

	function automatic logic [WIDTH-1:0] to_cell(input logic [VALUE_W-1:0] v);
		logic [63:0] wide;
		wide = 64'(v);
		return wide[WIDTH-1:0];
	endfunction

	function automatic logic [VALUE_W-1:0] from_cell(input logic [WIDTH-1:0] v);
		logic [63:0] wide;
		wide = 64'(v);
		return wide[VALUE_W-1:0];
	endfunction

endpackage

// ----- hdl/swmd_cell.sv -----
// One storage cell of a row: holds one entry and takes it from a neighbor or a load.
// Depends on swmd_pkg.
module swmd_cell (
	input  logic                       clk,
	input  swmd_pkg::cell_ctl_t        ctl,
	input  logic [swmd_pkg::WIDTH-1:0] lower_val,
	input  logic [swmd_pkg::WIDTH-1:0] higher_val,
	input  logic [swmd_pkg::WIDTH-1:0] load_val,
	output logic [swmd_pkg::WIDTH-1:0] val
);

	logic [swmd_pkg::WIDTH-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			value_q <= load_val;
		end else begin
			case (ctl.shift)
				swmd_pkg::SH_FROM_LOWER:  value_q <= lower_val;
				swmd_pkg::SH_FROM_HIGHER: value_q <= higher_val;
				default:                  value_q <= value_q;
			endcase
		end
	end

	assign val = value_q;

endmodule

// ----- hdl/swmd_row.sv -----
// A row of cells anchored at cell 0, which is the only entry read out.
// Depends on swmd_pkg and swmd_cell.
module swmd_row (
	input  logic                       clk,
	input  swmd_pkg::row_ctl_t         ctl,
	input  logic [swmd_pkg::WIDTH-1:0] wr_data,
	output logic [swmd_pkg::WIDTH-1:0] head
);

	logic [swmd_pkg::WIDTH-1:0] cell_val [swmd_pkg::ROW_LEN];

	for (genvar k = 0; k < swmd_pkg::ROW_LEN; k++) begin : g_cell
		logic [swmd_pkg::WIDTH-1:0] lower;
		logic [swmd_pkg::WIDTH-1:0] higher;
		swmd_pkg::cell_ctl_t        cctl;

		if (k == 0) begin : g_first
			assign lower = '0;
		end else begin : g_inner_lo
			assign lower = cell_val[k-1];
		end

		if (k == swmd_pkg::ROW_LEN - 1) begin : g_last
			assign higher = '0;
		end else begin : g_inner_hi
			assign higher = cell_val[k+1];
		end

		assign cctl.shift = ctl.shift;
		assign cctl.load  = ctl.wr_en && (ctl.wr_idx == swmd_pkg::IDX_W'(k));

		swmd_cell u_cell (
			.clk        (clk),
			.ctl        (cctl),
			.lower_val  (lower),
			.higher_val (higher),
			.load_val   (wr_data),
			.val        (cell_val[k])
		);
	end

	assign head = cell_val[0];

endmodule

// ----- hdl/stack_with_middle_delete_core.sv -----
// Top level of the bounded stack with middle access and middle delete.
// Depends on swmd_pkg and swmd_row (which builds on swmd_cell).
//
// Takes one command word per clock as long as the output is not held off, and returns
// one result word for each, in order. The accepting edge updates the rows of cells;
// the result stage then registers top, middle and count into the output word once the
// output register is free. While the output is held off, one more command is taken
// and staged, and then the input stops until the output word is taken.
// The stack is kept as an upper half (middle up to top) and a lower half (below the
// middle). The upper half lives in two rows holding the same entries, one anchored
// at the top and one at the middle, so both values are read at a fixed cell; the
// lower half is one row anchored at its top. Every operation moves each row by at
// most one place.
module stack_with_middle_delete_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  swmd_pkg::cmd_word_t cmd,
	output logic                res_valid,
	input  logic                res_ready,
	output swmd_pkg::res_word_t res
);

	logic [swmd_pkg::CNT_W-1:0] count_q;
	logic [swmd_pkg::CNT_W-1:0] count_d;
	logic [swmd_pkg::CNT_W-1:0] upper_size;
	logic [swmd_pkg::CNT_W-1:0] upper_size_m1;
	logic [swmd_pkg::IDX_W-1:0] su_idx;
	logic [swmd_pkg::IDX_W-1:0] su_m1_idx;
	logic                       is_full;
	logic                       is_empty;
	logic                       odd;
	logic                       do_op;
	logic                       advance;

	swmd_pkg::status_t          status_d;
	swmd_pkg::status_t          status_s1;
	logic                       valid_s1;
	logic                       res_valid_q;
	swmd_pkg::res_word_t        res_q;

	swmd_pkg::row_ctl_t         ut_ctl;
	swmd_pkg::row_ctl_t         ub_ctl;
	swmd_pkg::row_ctl_t         lt_ctl;
	logic [swmd_pkg::WIDTH-1:0] ut_data;
	logic [swmd_pkg::WIDTH-1:0] ub_data;
	logic [swmd_pkg::WIDTH-1:0] lt_data;
	logic [swmd_pkg::WIDTH-1:0] ut_head;
	logic [swmd_pkg::WIDTH-1:0] ub_head;
	logic [swmd_pkg::WIDTH-1:0] lt_head;
	logic [swmd_pkg::WIDTH-1:0] push_cell;

	assign is_full       = (count_q == swmd_pkg::CNT_W'(swmd_pkg::DEPTH));
	assign is_empty      = (count_q == '0);
	assign odd           = count_q[0];
	assign upper_size    = count_q - (count_q >> 1);
	assign upper_size_m1 = upper_size - swmd_pkg::CNT_W'(1);
	assign su_idx        = upper_size[swmd_pkg::IDX_W-1:0];
	assign su_m1_idx     = upper_size_m1[swmd_pkg::IDX_W-1:0];
	assign push_cell     = swmd_pkg::to_cell(cmd.push_value);

	assign advance   = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || advance;
	assign do_op     = cmd_valid && cmd_ready;

	// Row moves for each operation. The upper half holds ceil(count/2) entries; when
	// the count parity flips, one entry crosses between the halves at the middle.
	always_comb begin
		ut_ctl   = '{shift: swmd_pkg::SH_HOLD, wr_en: 1'b0, wr_idx: '0};
		ub_ctl   = '{shift: swmd_pkg::SH_HOLD, wr_en: 1'b0, wr_idx: '0};
		lt_ctl   = '{shift: swmd_pkg::SH_HOLD, wr_en: 1'b0, wr_idx: '0};
		ut_data  = push_cell;
		ub_data  = push_cell;
		lt_data  = ub_head;
		status_d = swmd_pkg::ST_OK;
		count_d  = count_q;
		if (do_op) begin
			unique case (cmd.opcode)
				swmd_pkg::OP_PUSH: begin
					if (is_full) begin
						status_d = swmd_pkg::ST_OVERFLOW;
					end else begin
						count_d = count_q + swmd_pkg::CNT_W'(1);
						ut_ctl  = '{shift: swmd_pkg::SH_FROM_LOWER, wr_en: 1'b1, wr_idx: '0};
						if (odd) begin
							// The old middle drops into the lower half.
							ub_ctl = '{shift: swmd_pkg::SH_FROM_HIGHER, wr_en: 1'b1,
								wr_idx: su_m1_idx};
							lt_ctl = '{shift: swmd_pkg::SH_FROM_LOWER, wr_en: 1'b1,
								wr_idx: '0};
						end else begin
							ub_ctl = '{shift: swmd_pkg::SH_HOLD, wr_en: 1'b1, wr_idx: su_idx};
						end
					end
				end
				swmd_pkg::OP_POP: begin
					if (is_empty) begin
						status_d = swmd_pkg::ST_UNDERFLOW;
					end else begin
						count_d = count_q - swmd_pkg::CNT_W'(1);
						ut_ctl  = '{shift: swmd_pkg::SH_FROM_HIGHER, wr_en: 1'b0, wr_idx: '0};
						if (!odd) begin
							// The top of the lower half becomes the new middle.
							ut_data = lt_head;
							ub_data = lt_head;
							ut_ctl  = '{shift: swmd_pkg::SH_FROM_HIGHER, wr_en: 1'b1,
								wr_idx: su_m1_idx};
							ub_ctl  = '{shift: swmd_pkg::SH_FROM_LOWER, wr_en: 1'b1,
								wr_idx: '0};
							lt_ctl  = '{shift: swmd_pkg::SH_FROM_HIGHER, wr_en: 1'b0,
								wr_idx: '0};
						end
					end
				end
				swmd_pkg::OP_DELMID: begin
					if (is_empty) begin
						status_d = swmd_pkg::ST_UNDERFLOW;
					end else begin
						count_d = count_q - swmd_pkg::CNT_W'(1);
						if (!odd) begin
							// The middle is replaced by the top of the lower half.
							ut_data = lt_head;
							ub_data = lt_head;
							ut_ctl  = '{shift: swmd_pkg::SH_HOLD, wr_en: 1'b1,
								wr_idx: su_m1_idx};
							ub_ctl  = '{shift: swmd_pkg::SH_HOLD, wr_en: 1'b1, wr_idx: '0};
							lt_ctl  = '{shift: swmd_pkg::SH_FROM_HIGHER, wr_en: 1'b0,
								wr_idx: '0};
						end else begin
							ub_ctl = '{shift: swmd_pkg::SH_FROM_HIGHER, wr_en: 1'b0,
								wr_idx: '0};
						end
					end
				end
				swmd_pkg::OP_QUERY: begin
					status_d = swmd_pkg::ST_OK;
				end
				default: begin
					status_d = swmd_pkg::ST_OK;
				end
			endcase
		end
	end

	swmd_row u_upper_top (
		.clk     (clk),
		.ctl     (ut_ctl),
		.wr_data (ut_data),
		.head    (ut_head)
	);

	swmd_row u_upper_mid (
		.clk     (clk),
		.ctl     (ub_ctl),
		.wr_data (ub_data),
		.head    (ub_head)
	);

	swmd_row u_lower_top (
		.clk     (clk),
		.ctl     (lt_ctl),
		.wr_data (lt_data),
		.head    (lt_head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (do_op) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_op) begin
			status_s1 <= status_d;
		end
		// The rows and count only change when a word is taken, which happens no
		// earlier than this edge, so they still show the state after the staged word.
		if (advance) begin
			res_q.status       <= status_s1;
			res_q.top_value    <= is_empty ? '0 : swmd_pkg::from_cell(ut_head);
			res_q.middle_value <= is_empty ? '0 : swmd_pkg::from_cell(ub_head);
			res_q.entry_count  <= swmd_pkg::COUNT_FIELD_W'(count_q);
			res_q.is_empty     <= is_empty;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
